// ===== rtl/itrd_pkg.sv =====
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared widths, constants and controller/datapath interface types for the
// signed integer to radix digits block.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int ALPHA_MAX   = 64;
  localparam int NUM_REGS    = 8;
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int BYTE_SEL_W  = $clog2(CFG_DATA_W / CHAR_W);
  localparam int ALPHA_IDX_W = $clog2(ALPHA_MAX);
  localparam int RADIX_W     = ALPHA_IDX_W + 1;
  localparam int STACK_DEPTH = VALUE_BITS;
  localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

  typedef struct packed {
    logic load_num;    // take a new number, restart the alphabet scan
    logic alpha_rd;    // read the alphabet word holding the selected byte
    logic rd_digit;    // address the alphabet by remainder instead of scan index
    logic scan_step;   // accept the checked byte, advance the scan index
    logic div_step;    // one restoring division step
    logic push;        // push the digit character, restart the division
    logic pop_rd;      // read the top of the digit stack
    logic load_minus;  // load '-' into the output register
    logic load_digit;  // load the popped character into the output register
  } itrd_cmd_t;

  typedef struct packed {
    logic byte_zero;   // scanned byte ends the alphabet
    logic byte_bad;    // scanned byte is not allowed or repeats
    logic scan_full;   // scan index is at the final alphabet slot
    logic short_alpha; // fewer than two characters scanned
    logic div_last;    // the current division step is the final one
    logic quot_zero;   // quotient is zero
    logic neg;         // number is negative
    logic stack_empty; // nothing left on the digit stack
  } itrd_sts_t;

endpackage

// ===== rtl/itrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: scans and checks the alphabet, runs the digit division loop,
// then unstacks the characters into the output register.
// ----------------------------------------------------------------------------
module itrd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  itrd_pkg::itrd_sts_t sts,
  output itrd_pkg::itrd_cmd_t cmd
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SCAN_RD    = 4'd1;
  localparam logic [3:0] S_SCAN_CHK   = 4'd2;
  localparam logic [3:0] S_DIV        = 4'd3;
  localparam logic [3:0] S_PUSH_RD    = 4'd4;
  localparam logic [3:0] S_PUSH       = 4'd5;
  localparam logic [3:0] S_EMIT_MINUS = 4'd6;
  localparam logic [3:0] S_POP_RD     = 4'd7;
  localparam logic [3:0] S_POP_LD     = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_num = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.alpha_rd = 1'b1;
        state_nxt    = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.byte_zero) begin
          state_nxt = sts.short_alpha ? S_IDLE : S_DIV;
        end else if (sts.byte_bad) begin
          // bad alphabet: drop the number
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = sts.scan_full ? S_DIV : S_SCAN_RD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_PUSH_RD;
      end
      S_PUSH_RD: begin
        cmd.alpha_rd = 1'b1;
        cmd.rd_digit = 1'b1;
        state_nxt    = S_PUSH;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (sts.quot_zero) begin
          state_nxt = sts.neg ? S_EMIT_MINUS : S_POP_RD;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_EMIT_MINUS: begin
        if (out_free) begin
          cmd.load_minus = 1'b1;
          state_nxt      = S_POP_RD;
        end
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_LD;
      end
      S_POP_LD: begin
        if (out_free) begin
          cmd.load_digit = 1'b1;
          state_nxt      = sts.stack_empty ? S_IDLE : S_POP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_minus || cmd.load_digit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_minus || cmd.load_digit) |-> (!out_valid_r || out_tready))
    else $error("output register loaded while a transaction is pending");

  a_div_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> (state_r == S_PUSH_RD))
    else $error("division did not hand over to digit push");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_num, cmd.scan_step, cmd.div_step, cmd.push,
              cmd.pop_rd, cmd.load_minus, cmd.load_digit}))
    else $error("more than one datapath command at once");

endmodule

// ===== rtl/itrd_dp.sv =====
// ----------------------------------------------------------------------------
// itrd_dp
// Datapath: alphabet store, duplicate/validity checker, bit-serial divider,
// digit stack and output register.
// ----------------------------------------------------------------------------
module itrd_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [itrd_pkg::VALUE_BITS-1:0]      in_number,
  output logic [itrd_pkg::CHAR_W-1:0]          out_char,
  output logic                                 out_last,
  input  itrd_pkg::itrd_cmd_t                  cmd,
  output itrd_pkg::itrd_sts_t                  sts
);

  localparam int CODE_W = 6;
  localparam int SEEN_W = 1 << CODE_W;

  localparam logic [itrd_pkg::CHAR_W-1:0] CH_SLASH    = 8'h2F;
  localparam logic [itrd_pkg::CHAR_W-1:0] CH_COLON    = 8'h3A;
  localparam logic [itrd_pkg::CHAR_W-1:0] CH_AT       = 8'h40;
  localparam logic [itrd_pkg::CHAR_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [itrd_pkg::CHAR_W-1:0] CH_LOWER_A  = 8'h61;
  localparam logic [itrd_pkg::CHAR_W-1:0] CH_LBRACE   = 8'h7B;
  localparam logic [itrd_pkg::CHAR_W-1:0] CH_MINUS    = 8'h2D;

  function automatic logic char_ok(input logic [itrd_pkg::CHAR_W-1:0] c);
    return (c > CH_SLASH && c < CH_COLON) || (c > CH_AT && c < CH_LBRACKET) ||
           (c >= CH_LOWER_A && c < CH_LBRACE);
  endfunction

  // map 0-9, A-Z, a-z onto 0..61
  function automatic logic [CODE_W-1:0] char_code(input logic [itrd_pkg::CHAR_W-1:0] c);
    logic [itrd_pkg::CHAR_W-1:0] t;
    if (c < CH_COLON) begin
      t = c - CH_SLASH - 8'd1;
    end else if (c < CH_LBRACKET) begin
      t = c - CH_AT + 8'd9;
    end else begin
      t = c - CH_LOWER_A + 8'd36;
    end
    return t[CODE_W-1:0];
  endfunction

  // alphabet store
  logic [itrd_pkg::CFG_DATA_W-1:0]  alpha_mem_r [itrd_pkg::NUM_REGS];
  logic [itrd_pkg::NUM_REGS-1:0]    alpha_vld_r;
  logic [itrd_pkg::CFG_DATA_W-1:0]  alpha_rdata_r;
  logic [itrd_pkg::BYTE_SEL_W-1:0]  alpha_sel_r;
  logic                             cfg_wr;
  logic [itrd_pkg::ALPHA_IDX_W-1:0] rd_addr;
  logic [itrd_pkg::REG_IDX_W-1:0]   rd_word;
  logic [itrd_pkg::CHAR_W-1:0]      alpha_byte;

  // scan / check
  logic [itrd_pkg::RADIX_W-1:0]     idx_r;
  logic [SEEN_W-1:0]                seen_r;
  logic [CODE_W-1:0]                code;

  // divider
  logic [itrd_pkg::VALUE_BITS-1:0]  mag_r;
  logic                             neg_r;
  logic [itrd_pkg::ALPHA_IDX_W-1:0] rem_r;
  logic [itrd_pkg::BIT_CNT_W-1:0]   bit_cnt_r;
  logic [itrd_pkg::RADIX_W-1:0]     rem_shift;
  logic [itrd_pkg::RADIX_W-1:0]     rem_sub;
  logic                             rem_ge;
  logic [itrd_pkg::ALPHA_IDX_W-1:0] rem_nxt;

  // digit stack and output
  logic [itrd_pkg::CHAR_W-1:0]      stack_mem_r [itrd_pkg::STACK_DEPTH];
  logic [itrd_pkg::CHAR_W-1:0]      stack_rdata_r;
  logic [itrd_pkg::SP_W-1:0]        sp_r;
  logic [itrd_pkg::SP_W-1:0]        sp_dec;
  logic [itrd_pkg::CHAR_W-1:0]      out_char_r;
  logic                             out_last_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && (cfg_index < itrd_pkg::CFG_IDX_W'(itrd_pkg::NUM_REGS));

  assign rd_addr    = cmd.rd_digit ? rem_r : idx_r[itrd_pkg::ALPHA_IDX_W-1:0];
  assign rd_word    = rd_addr[itrd_pkg::ALPHA_IDX_W-1:itrd_pkg::BYTE_SEL_W];
  assign alpha_byte = alpha_rdata_r[alpha_sel_r * itrd_pkg::CHAR_W +: itrd_pkg::CHAR_W];

  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      alpha_mem_r[cfg_index[itrd_pkg::REG_IDX_W-1:0]] <= cfg_data;
    end
    if (cmd.alpha_rd) begin
      // a register never written reads as zero
      alpha_rdata_r <= alpha_vld_r[rd_word] ? alpha_mem_r[rd_word] : '0;
      alpha_sel_r   <= rd_addr[itrd_pkg::BYTE_SEL_W-1:0];
    end
  end

  assign code = char_code(alpha_byte);

  assign rem_shift = {rem_r, mag_r[itrd_pkg::VALUE_BITS-1]};
  assign rem_ge    = (rem_shift >= idx_r);
  assign rem_sub   = rem_shift - idx_r;
  assign rem_nxt   = rem_ge ? rem_sub[itrd_pkg::ALPHA_IDX_W-1:0]
                            : rem_shift[itrd_pkg::ALPHA_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_num) begin
      neg_r     <= in_number[itrd_pkg::VALUE_BITS-1];
      mag_r     <= in_number[itrd_pkg::VALUE_BITS-1] ?
                   (itrd_pkg::VALUE_BITS'(0) - in_number) : in_number;
      idx_r     <= '0;
      seen_r    <= '0;
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end else begin
      if (cmd.scan_step) begin
        idx_r        <= idx_r + itrd_pkg::RADIX_W'(1);
        seen_r[code] <= 1'b1;
      end
      if (cmd.div_step) begin
        mag_r     <= {mag_r[itrd_pkg::VALUE_BITS-2:0], rem_ge};
        rem_r     <= rem_nxt;
        bit_cnt_r <= bit_cnt_r + itrd_pkg::BIT_CNT_W'(1);
      end
      if (cmd.push) begin
        rem_r     <= '0;
        bit_cnt_r <= '0;
      end
    end
  end

  assign sp_dec = sp_r - itrd_pkg::SP_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem_r[sp_r[itrd_pkg::STACK_IDX_W-1:0]] <= alpha_byte;
    end
    if (cmd.pop_rd) begin
      stack_rdata_r <= stack_mem_r[sp_dec[itrd_pkg::STACK_IDX_W-1:0]];
    end
    if (cmd.load_minus) begin
      out_char_r <= CH_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.load_digit) begin
      out_char_r <= stack_rdata_r;
      out_last_r <= (sp_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_vld_r <= '0;
      sp_r        <= '0;
    end else begin
      if (cfg_wr) begin
        alpha_vld_r[cfg_index[itrd_pkg::REG_IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.load_num) begin
        sp_r <= '0;
      end else if (cmd.push) begin
        sp_r <= sp_r + itrd_pkg::SP_W'(1);
      end else if (cmd.pop_rd) begin
        sp_r <= sp_dec;
      end
    end
  end

  assign sts.byte_zero   = (alpha_byte == '0);
  assign sts.byte_bad    = !char_ok(alpha_byte) || seen_r[code];
  assign sts.scan_full   = (idx_r == itrd_pkg::RADIX_W'(itrd_pkg::ALPHA_MAX - 1));
  assign sts.short_alpha = (idx_r < itrd_pkg::RADIX_W'(2));
  assign sts.div_last    = (bit_cnt_r == itrd_pkg::BIT_CNT_W'(itrd_pkg::VALUE_BITS - 1));
  assign sts.quot_zero   = (mag_r == '0);
  assign sts.neg         = neg_r;
  assign sts.stack_empty = (sp_r == '0);

  assign out_char = out_char_r;
  assign out_last = out_last_r;

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (sp_r < itrd_pkg::SP_W'(itrd_pkg::STACK_DEPTH)))
    else $error("digit stack overflow");

endmodule

// ===== rtl/signed_integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// Writes a signed 32-bit integer as text in the radix of a configured digit
// alphabet, most significant character first, one character per transaction.
//
//   channel  direction  handshake           payload
//   in_      slave      in_tvalid/tready    in_tdata[31:0]  number
//   out_     master     out_tvalid/tready   out_tdata[7:0]  char, out_tlast
//   cfg_     slave      cfg_valid/ready     cfg_index, cfg_data (alphabet word)
//
// Per number: it is taken, an alphabet of L bytes (up to 64) is scanned, each
// digit takes a divider step per bit, a lookup and a push, then a minus sign
// if negative, then each character unstacked; worst: base 2, most negative.
// An invalid alphabet gives no output; synchronous reset on rst_n zeroes it.
// A stalled out_tready holds the sequencer only when a character is due; the
// next number is taken while the final character still waits.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [itrd_pkg::VALUE_BITS-1:0]   in_tdata,   // [31:0] number
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [itrd_pkg::CHAR_W-1:0]       out_tdata,  // [7:0] out_char
  output logic                              out_tlast,  // last_char
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  itrd_pkg::itrd_cmd_t cmd;
  itrd_pkg::itrd_sts_t sts;

  itrd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  itrd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_number  (in_tdata),
    .out_char   (out_tdata),
    .out_last   (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
